/* src/rc4_pkg.sv */
// Shared types and constants for the RC4 cipher engine.
// Used by rc4_ram, rc4_ctrl and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

  localparam int ByteW = 8;
  localparam int AddrW = 8;
  localparam int Depth = 256;
  localparam int LenW  = 9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_WK,
    ST_KS_WJ,
    ST_DT_J,
    ST_DT_SW,
    ST_DT_OUT
  } state_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ByteW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] value;
    logic             no_key;
  } res_t;

endpackage

`default_nettype wire

/* src/rc4_ram.sv */
// 256 x 8 synchronous memory with one write port and one registered read port.
// Depends on rc4_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module rc4_ram (
  input  wire logic                      clk,
  input  wire rc4_pkg::mem_req_t         req,
  output logic [rc4_pkg::ByteW-1:0]      rdata
);

  logic [rc4_pkg::ByteW-1:0] mem [rc4_pkg::Depth];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read-first: a read of the entry being written returns the old value.
  // The data register holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

/* src/rc4_ctrl.sv */
// Sequencer for the RC4 engine: key loading, key schedule and keystream swaps.
// Drives the permutation and key store memories; depends on rc4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rc4_ctrl #(
  parameter int KEY_MAX = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire logic                       command,
  input  wire logic [rc4_pkg::ByteW-1:0]  data_byte,
  input  wire logic                       last_key_byte,
  input  wire logic                       res_free,
  output rc4_pkg::res_t                   res,
  output rc4_pkg::mem_req_t               perm_req,
  input  wire logic [rc4_pkg::ByteW-1:0]  perm_rdata,
  output rc4_pkg::mem_req_t               key_req,
  input  wire logic [rc4_pkg::ByteW-1:0]  key_rdata
);

  localparam logic [rc4_pkg::LenW-1:0] KeyMaxC = rc4_pkg::LenW'(KEY_MAX);

  rc4_pkg::state_t            state, state_next;
  logic [rc4_pkg::AddrW-1:0]  cnt, cnt_next;
  logic [rc4_pkg::AddrW-1:0]  kidx, kidx_next;
  logic [rc4_pkg::LenW-1:0]   key_len, key_len_next;
  logic [rc4_pkg::AddrW-1:0]  idx_i, idx_i_next;
  logic [rc4_pkg::AddrW-1:0]  idx_j, idx_j_next;
  logic                       keyed, keyed_next;
  logic [rc4_pkg::ByteW-1:0]  sk, sk_next;
  logic [rc4_pkg::ByteW-1:0]  sj, sj_next;
  logic [rc4_pkg::ByteW-1:0]  dbyte, dbyte_next;
  logic                       fwd_i, fwd_i_next;
  logic                       fwd_j, fwd_j_next;
  logic                       req_fire;
  logic [rc4_pkg::ByteW-1:0]  kb;
  logic [rc4_pkg::ByteW-1:0]  ks;
  logic [rc4_pkg::AddrW-1:0]  tsum;

  assign req_stall = (state != rc4_pkg::ST_IDLE) || !res_free;
  assign req_fire  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rc4_pkg::ST_IDLE;
      key_len <= '0;
      idx_i   <= '0;
      idx_j   <= '0;
      keyed   <= 1'b0;
    end else begin
      state   <= state_next;
      key_len <= key_len_next;
      idx_i   <= idx_i_next;
      idx_j   <= idx_j_next;
      keyed   <= keyed_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt   <= cnt_next;
    kidx  <= kidx_next;
    sk    <= sk_next;
    sj    <= sj_next;
    dbyte <= dbyte_next;
    fwd_i <= fwd_i_next;
    fwd_j <= fwd_j_next;
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    kidx_next    = kidx;
    key_len_next = key_len;
    idx_i_next   = idx_i;
    idx_j_next   = idx_j;
    keyed_next   = keyed;
    sk_next      = sk;
    sj_next      = sj;
    dbyte_next   = dbyte;
    fwd_i_next   = fwd_i;
    fwd_j_next   = fwd_j;
    perm_req     = '0;
    key_req      = '0;
    res          = '0;
    kb           = (key_len == '0) ? '0 : key_rdata;
    tsum         = sk + perm_rdata;
    // After the swap, entry i holds the old S[j] and entry j the old S[i];
    // the memory read was issued before the swap was complete.
    ks           = fwd_i ? sj : (fwd_j ? sk : perm_rdata);

    case (state)
      rc4_pkg::ST_IDLE: begin
        if (req_fire) begin
          if (!command) begin
            if (key_len < KeyMaxC) begin
              key_req.we    = 1'b1;
              key_req.waddr = key_len[rc4_pkg::AddrW-1:0];
              key_req.wdata = data_byte;
              key_len_next  = key_len + rc4_pkg::LenW'(1);
            end
            if (last_key_byte) begin
              cnt_next   = '0;
              state_next = rc4_pkg::ST_INIT;
            end
          end else if (!keyed) begin
            res.valid  = 1'b1;
            res.value  = data_byte;
            res.no_key = 1'b1;
          end else begin
            idx_i_next     = idx_i + rc4_pkg::AddrW'(1);
            perm_req.re    = 1'b1;
            perm_req.raddr = idx_i + rc4_pkg::AddrW'(1);
            dbyte_next     = data_byte;
            state_next     = rc4_pkg::ST_DT_J;
          end
        end
      end

      rc4_pkg::ST_INIT: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = cnt;
        perm_req.wdata = cnt;
        cnt_next       = cnt + rc4_pkg::AddrW'(1);
        if (cnt == '1) begin
          kidx_next  = '0;
          idx_j_next = '0;
          state_next = rc4_pkg::ST_KS_RD;
        end
      end

      rc4_pkg::ST_KS_RD: begin
        perm_req.re    = 1'b1;
        perm_req.raddr = cnt;
        key_req.re     = 1'b1;
        key_req.raddr  = kidx;
        state_next     = rc4_pkg::ST_KS_J;
      end

      rc4_pkg::ST_KS_J: begin
        sk_next        = perm_rdata;
        idx_j_next     = idx_j + perm_rdata + kb;
        perm_req.re    = 1'b1;
        perm_req.raddr = idx_j + perm_rdata + kb;
        if ({1'b0, kidx} + rc4_pkg::LenW'(1) >= key_len) begin
          kidx_next = '0;
        end else begin
          kidx_next = kidx + rc4_pkg::AddrW'(1);
        end
        state_next     = rc4_pkg::ST_KS_WK;
      end

      rc4_pkg::ST_KS_WK: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = cnt;
        perm_req.wdata = perm_rdata;
        state_next     = rc4_pkg::ST_KS_WJ;
      end

      rc4_pkg::ST_KS_WJ: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = idx_j;
        perm_req.wdata = sk;
        cnt_next       = cnt + rc4_pkg::AddrW'(1);
        if (cnt == '1) begin
          idx_i_next   = '0;
          idx_j_next   = '0;
          keyed_next   = 1'b1;
          key_len_next = '0;
          state_next   = rc4_pkg::ST_IDLE;
        end else begin
          state_next   = rc4_pkg::ST_KS_RD;
        end
      end

      rc4_pkg::ST_DT_J: begin
        sk_next        = perm_rdata;
        idx_j_next     = idx_j + perm_rdata;
        perm_req.re    = 1'b1;
        perm_req.raddr = idx_j + perm_rdata;
        state_next     = rc4_pkg::ST_DT_SW;
      end

      rc4_pkg::ST_DT_SW: begin
        sj_next        = perm_rdata;
        perm_req.we    = 1'b1;
        perm_req.waddr = idx_i;
        perm_req.wdata = perm_rdata;
        perm_req.re    = 1'b1;
        perm_req.raddr = tsum;
        fwd_i_next     = (tsum == idx_i);
        fwd_j_next     = (tsum == idx_j);
        state_next     = rc4_pkg::ST_DT_OUT;
      end

      rc4_pkg::ST_DT_OUT: begin
        // The write is repeated harmlessly while the result waits for room.
        perm_req.we    = 1'b1;
        perm_req.waddr = idx_j;
        perm_req.wdata = sk;
        if (res_free) begin
          res.valid  = 1'b1;
          res.value  = dbyte ^ ks;
          res.no_key = 1'b0;
          state_next = rc4_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = rc4_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_keyed_sticks: assert property (@(posedge clk) disable iff (rst)
    keyed |=> keyed)
    else $error("keyed flag cleared after a key was scheduled");

  a_key_len_bound: assert property (@(posedge clk) disable iff (rst)
    key_len <= KeyMaxC)
    else $error("key length beyond the key store limit");

  a_res_states: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (state == rc4_pkg::ST_IDLE || state == rc4_pkg::ST_DT_OUT))
    else $error("result produced outside the idle or output state");

  a_sched_end: assert property (@(posedge clk) disable iff (rst)
    (state == rc4_pkg::ST_KS_WJ && cnt == '1) |=>
      (idx_i == '0 && idx_j == '0 && keyed && key_len == '0
       && state == rc4_pkg::ST_IDLE))
    else $error("key schedule did not finish cleanly");
`endif

endmodule

`default_nettype wire

/* src/rc4_keystream_cipher.sv */
// A keyed data byte passes ST_DT_J, ST_DT_SW and ST_DT_OUT to the result register, waiting
// in ST_DT_OUT while that register is full; an unkeyed data byte goes to it from idle, and a
// key byte gives no result. New bytes are taken only in idle. The last key byte stalls the
// input through the permutation fill and the schedule steps ST_KS_RD, ST_KS_J, ST_KS_WK and
// ST_KS_WJ, split by the single write port of the permutation memory.
// Reset clears the indices, key length, keyed flag and result valid flag, but not the memories.
// Top level of the RC4 engine: sequencer, two memories and the result register.
// Depends on rc4_pkg, rc4_ram and rc4_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module rc4_keystream_cipher #(
  parameter int KEY_MAX = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire logic                       command,
  input  wire logic [rc4_pkg::ByteW-1:0]  data_byte,
  input  wire logic                       last_key_byte,
  output logic                            rsp_valid,
  input  wire logic                       rsp_stall,
  output logic [rc4_pkg::ByteW-1:0]       out_byte,
  output logic                            no_key
);

  rc4_pkg::mem_req_t          perm_req;
  rc4_pkg::mem_req_t          key_req;
  logic [rc4_pkg::ByteW-1:0]  perm_rdata;
  logic [rc4_pkg::ByteW-1:0]  key_rdata;
  rc4_pkg::res_t              res;
  logic                       res_free;

  // The result register may be reloaded in the cycle its transfer completes.
  assign res_free = !rsp_valid || !rsp_stall;

  rc4_ctrl #(
    .KEY_MAX (KEY_MAX)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .command       (command),
    .data_byte     (data_byte),
    .last_key_byte (last_key_byte),
    .res_free      (res_free),
    .res           (res),
    .perm_req      (perm_req),
    .perm_rdata    (perm_rdata),
    .key_req       (key_req),
    .key_rdata     (key_rdata)
  );

  rc4_ram u_perm (
    .clk   (clk),
    .req   (perm_req),
    .rdata (perm_rdata)
  );

  rc4_ram u_key (
    .clk   (clk),
    .req   (key_req),
    .rdata (key_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res.valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_byte <= res.value;
      no_key   <= res.no_key;
    end
  end

endmodule

`default_nettype wire
